// ----- design/pbsr_pkg.sv -----
// Package for the privacy box to screen region block.
// Holds the channel payload structs, stage load controls, register indexes and
// the fixed-point constants used by the top level and the axis pipeline.
package pbsr_pkg;

   // Register indexes of the configuration port.
   typedef enum logic [3:0] {
      REG_FACE_MODE        = 4'd0,
      REG_STRICT_FACE_MODE = 4'd1,
      REG_SCALE_X          = 4'd2,
      REG_SCALE_Y          = 4'd3,
      REG_OFFSET_X         = 4'd4,
      REG_OFFSET_Y         = 4'd5,
      REG_FRAME_WIDTH      = 4'd6,
      REG_FRAME_HEIGHT     = 4'd7
   } reg_index_type;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // Growth factors in Q1.8 and unit values in Q12.4 and Q.12.
   localparam logic [8:0]  GROW_OCCLUDED = 9'd397;
   localparam logic [8:0]  GROW_NORMAL   = 9'd333;
   localparam logic [15:0] ONE_Q4        = 16'd16;
   localparam logic [24:0] ONE_Q12       = 25'd4096;

   // Internal widths of one axis.
   localparam int GROWN_W    = 25;  // length times growth factor, Q.12
   localparam int EDGE_W     = 27;  // grown left edge, Q.13
   localparam int POS_PROD_W = 44;  // edge times scale plus offset, Q.25
   localparam int SIZE_PROD_W = 41; // grown size times scale, Q.24
   localparam int POS_FRAC   = 25;
   localparam int SIZE_FRAC  = 24;
   localparam int OFF_SHIFT  = 21;
   localparam int START_W    = 21;  // signed screen coordinate
   localparam int SIZE_W     = 18;  // unsigned screen size

   typedef struct packed {
      logic               anonymize_flag;
      logic signed [15:0] body_x;
      logic signed [15:0] body_y;
      logic [15:0]        body_w;
      logic [15:0]        body_h;
      logic               body_occluded;
      logic               face_present;
      logic signed [15:0] face_x;
      logic signed [15:0] face_y;
      logic [15:0]        face_w;
      logic [15:0]        face_h;
      logic signed [15:0] track_number;
   } req_type;

   typedef struct packed {
      logic [11:0]        roi_left;
      logic [11:0]        roi_top;
      logic [12:0]        roi_width;
      logic [12:0]        roi_height;
      logic signed [15:0] source_track;
      logic               source_is_face;
      logic               target_is_face;
   } rsp_type;

   // Load enables of the three register stages inside one axis pipeline.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_load_type;

endpackage

// ----- design/pbsr_axis.sv -----
// One axis of the box mapping: growth about the center, scale, offset and rounding.
// Three register stages; depends on pbsr_pkg for widths and constants.
module pbsr_axis (
   input  logic                                  clock,
   input  pbsr_pkg::stage_load_type              load,
   input  logic signed [15:0]                    pos,
   input  logic [15:0]                           len,
   input  logic                                  occ,
   input  logic [15:0]                           scale,
   input  logic signed [15:0]                    off,
   output logic signed [pbsr_pkg::START_W-1:0]   start_o,
   output logic [pbsr_pkg::SIZE_W-1:0]           size_o
);

   logic [pbsr_pkg::GROWN_W-1:0]            grown_raw;
   logic [pbsr_pkg::GROWN_W-1:0]            grown_in, grown_ff;
   logic signed [pbsr_pkg::EDGE_W-1:0]      pos_q13, len_q13, grown_q13;
   logic signed [pbsr_pkg::EDGE_W-1:0]      edge_q13_in, edge_q13_ff;
   logic signed [pbsr_pkg::POS_PROD_W-1:0]  pos_prod_in, pos_prod_ff;
   logic [pbsr_pkg::SIZE_PROD_W-1:0]        size_prod_in, size_prod_ff;
   logic [pbsr_pkg::POS_PROD_W-1:0]         pos_mag, pos_rnd;
   logic [pbsr_pkg::SIZE_PROD_W-1:0]        size_rnd;
   logic signed [pbsr_pkg::START_W-1:0]     start_in, start_ff;
   logic [pbsr_pkg::SIZE_W-1:0]             size_in, size_ff;

   // Stage 1: grown length (at least one pixel) and the grown left edge.
   always_comb begin
      grown_raw = pbsr_pkg::GROWN_W'(len) *
                  pbsr_pkg::GROWN_W'(occ ? pbsr_pkg::GROW_OCCLUDED : pbsr_pkg::GROW_NORMAL);
      grown_in  = (grown_raw < pbsr_pkg::ONE_Q12) ? pbsr_pkg::ONE_Q12 : grown_raw;
      pos_q13   = pbsr_pkg::EDGE_W'(pos) <<< 9;
      len_q13   = $signed({3'b000, len, 8'h00});
      grown_q13 = $signed({2'b00, grown_in});
      edge_q13_in = pos_q13 + len_q13 - grown_q13;
   end

   // Stage 2: multiply by the scale; the offset joins the edge product.
   always_comb begin
      pos_prod_in = edge_q13_ff * $signed({1'b0, scale}) +
                    (pbsr_pkg::POS_PROD_W'(off) <<< pbsr_pkg::OFF_SHIFT);
      size_prod_in = pbsr_pkg::SIZE_PROD_W'(grown_ff) * pbsr_pkg::SIZE_PROD_W'(scale);
   end

   // Stage 3: round half away from zero to whole pixels.
   always_comb begin
      pos_mag  = pos_prod_ff[pbsr_pkg::POS_PROD_W-1] ? 
                 pbsr_pkg::POS_PROD_W'(-pos_prod_ff) : pbsr_pkg::POS_PROD_W'(pos_prod_ff);
      pos_rnd  = (pos_mag + (pbsr_pkg::POS_PROD_W'(1) << (pbsr_pkg::POS_FRAC - 1)))
                 >> pbsr_pkg::POS_FRAC;
      start_in = pos_prod_ff[pbsr_pkg::POS_PROD_W-1] ?
                 $signed(pbsr_pkg::START_W'(0) - pbsr_pkg::START_W'(pos_rnd)) :
                 $signed(pbsr_pkg::START_W'(pos_rnd));
      size_rnd = (size_prod_ff + (pbsr_pkg::SIZE_PROD_W'(1) << (pbsr_pkg::SIZE_FRAC - 1)))
                 >> pbsr_pkg::SIZE_FRAC;
      size_in  = pbsr_pkg::SIZE_W'(size_rnd);
   end

   always_ff @(posedge clock) begin
      if (load.s1) begin
         grown_ff    <= grown_in;
         edge_q13_ff <= edge_q13_in;
      end
      if (load.s2) begin
         pos_prod_ff  <= pos_prod_in;
         size_prod_ff <= size_prod_in;
      end
      if (load.s3) begin
         start_ff <= start_in;
         size_ff  <= size_in;
      end
   end

   assign start_o = start_ff;
   assign size_o  = size_ff;

endmodule

// ----- design/privacy_box_to_screen_roi_top.sv -----
// Top level of the privacy box to screen region block: control, clipping, selection.
// Depends on pbsr_pkg and instantiates four pbsr_axis pipelines.

// Each accepted box beat yields zero or one screen region beat. The block takes one box
// per clock unless every stage holds a box and the output is stalled; a result passes
// through the three stages of the axis pipelines (grow, scale multiply, round), one clip
// stage and the output register. Face and body boxes are mapped side by side, so the
// fallback from a too small face region to the body box needs no second pass.
// Every stage moves on its own when the stage after it is free, so bubbles close up
// under a stalled output. Configuration is written through the csr port, which is
// always ready; write it only while no box is in flight.
module privacy_box_to_screen_roi_top #(
   parameter int MAX_FRAME_DIM = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  pbsr_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output pbsr_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pbsr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pbsr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam logic signed [pbsr_pkg::START_W-1:0] MAX_DIM_S =
      pbsr_pkg::START_W'(MAX_FRAME_DIM);

   // Configuration registers.
   logic               face_mode_ff, strict_face_mode_ff;
   logic [15:0]        scale_x_ff, scale_y_ff;
   logic signed [15:0] offset_x_ff, offset_y_ff;
   logic [12:0]        frame_width_ff, frame_height_ff;

   // Pipeline control.
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic ld1, ld2, ld3, ld4, ldo;
   logic v1_in, rsp_valid_in;
   logic face_ok, drop;
   pbsr_pkg::stage_load_type axis_load;

   // Side data traveling with each box.
   logic               use_face1_ff, use_face2_ff, use_face3_ff, use_face4_ff;
   logic signed [15:0] track1_ff, track2_ff, track3_ff, track4_ff;

   // Axis results.
   logic signed [pbsr_pkg::START_W-1:0] fx_start, fy_start, bx_start, by_start;
   logic [pbsr_pkg::SIZE_W-1:0]         fx_size, fy_size, bx_size, by_size;

   // Clip stage.
   logic signed [pbsr_pkg::START_W-1:0] fw_eff, fh_eff;
   logic signed [pbsr_pkg::START_W-1:0] f_x1_ff, f_x2_ff, f_y1_ff, f_y2_ff;
   logic signed [pbsr_pkg::START_W-1:0] b_x1_ff, b_x2_ff, b_y1_ff, b_y2_ff;
   logic                                f_zero_ff, b_zero_ff;

   // Final selection.
   logic signed [pbsr_pkg::START_W-1:0] f_w, f_h, b_w, b_h;
   logic                                f_ok, b_ok, take_face;
   pbsr_pkg::rsp_type                   rsp_data_in, rsp_data_ff;

   function automatic logic signed [pbsr_pkg::START_W-1:0] clip_lo(
      input logic signed [pbsr_pkg::START_W-1:0] start
   );
      clip_lo = (start > 0) ? start : '0;
   endfunction

   function automatic logic signed [pbsr_pkg::START_W-1:0] clip_hi(
      input logic signed [pbsr_pkg::START_W-1:0] start,
      input logic [pbsr_pkg::SIZE_W-1:0]         size,
      input logic signed [pbsr_pkg::START_W-1:0] lim
   );
      logic signed [pbsr_pkg::START_W-1:0] stop;
      stop    = start + $signed(pbsr_pkg::START_W'(size));
      clip_hi = (stop < lim) ? stop : lim;
   endfunction

   // Configuration port.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_mode_ff        <= 1'b0;
         strict_face_mode_ff <= 1'b0;
         scale_x_ff          <= 16'd4096;
         scale_y_ff          <= 16'd4096;
         offset_x_ff         <= '0;
         offset_y_ff         <= '0;
         frame_width_ff      <= '0;
         frame_height_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pbsr_pkg::REG_FACE_MODE:        face_mode_ff        <= csr_wdata[0];
            pbsr_pkg::REG_STRICT_FACE_MODE: strict_face_mode_ff <= csr_wdata[0];
            pbsr_pkg::REG_SCALE_X:          scale_x_ff          <= csr_wdata;
            pbsr_pkg::REG_SCALE_Y:          scale_y_ff          <= csr_wdata;
            pbsr_pkg::REG_OFFSET_X:         offset_x_ff         <= $signed(csr_wdata);
            pbsr_pkg::REG_OFFSET_Y:         offset_y_ff         <= $signed(csr_wdata);
            pbsr_pkg::REG_FRAME_WIDTH:      frame_width_ff      <= csr_wdata[12:0];
            pbsr_pkg::REG_FRAME_HEIGHT:     frame_height_ff     <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // A stage loads when it is empty or its contents move on in the same cycle.
   always_comb begin
      ldo = !rsp_valid_ff || !rsp_stall;
      ld4 = !v4_ff || ldo;
      ld3 = !v3_ff || ld4;
      ld2 = !v2_ff || ld3;
      ld1 = !v1_ff || ld2;
      axis_load.s1 = ld1;
      axis_load.s2 = ld2;
      axis_load.s3 = ld3;
   end

   assign req_stall = !ld1;

   // Boxes that can never give a region are dropped on entry.
   always_comb begin
      face_ok = req_data.face_present && (req_data.face_w > pbsr_pkg::ONE_Q4) &&
                (req_data.face_h > pbsr_pkg::ONE_Q4);
      drop    = !req_data.anonymize_flag || (req_data.body_w <= pbsr_pkg::ONE_Q4) ||
                (req_data.body_h <= pbsr_pkg::ONE_Q4) ||
                (strict_face_mode_ff && face_mode_ff && !face_ok) ||
                (frame_width_ff == '0) || (frame_height_ff == '0);
      v1_in   = req_valid && !drop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld1) v1_ff <= v1_in;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
         if (ld4) v4_ff <= v3_ff;
         if (ldo) rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         use_face1_ff <= face_mode_ff && face_ok;
         track1_ff    <= req_data.track_number;
      end
      if (ld2) begin
         use_face2_ff <= use_face1_ff;
         track2_ff    <= track1_ff;
      end
      if (ld3) begin
         use_face3_ff <= use_face2_ff;
         track3_ff    <= track2_ff;
      end
   end

   // A face box is never treated as occluded.
   pbsr_axis u_face_x (
      .clock(clock), .load(axis_load), .pos(req_data.face_x), .len(req_data.face_w),
      .occ(1'b0), .scale(scale_x_ff), .off(offset_x_ff),
      .start_o(fx_start), .size_o(fx_size)
   );

   pbsr_axis u_face_y (
      .clock(clock), .load(axis_load), .pos(req_data.face_y), .len(req_data.face_h),
      .occ(1'b0), .scale(scale_y_ff), .off(offset_y_ff),
      .start_o(fy_start), .size_o(fy_size)
   );

   pbsr_axis u_body_x (
      .clock(clock), .load(axis_load), .pos(req_data.body_x), .len(req_data.body_w),
      .occ(req_data.body_occluded), .scale(scale_x_ff), .off(offset_x_ff),
      .start_o(bx_start), .size_o(bx_size)
   );

   pbsr_axis u_body_y (
      .clock(clock), .load(axis_load), .pos(req_data.body_y), .len(req_data.body_h),
      .occ(req_data.body_occluded), .scale(scale_y_ff), .off(offset_y_ff),
      .start_o(by_start), .size_o(by_size)
   );

   // Frame size, limited to the largest supported dimension.
   always_comb begin
      fw_eff = $signed(pbsr_pkg::START_W'(frame_width_ff));
      fh_eff = $signed(pbsr_pkg::START_W'(frame_height_ff));
      if (fw_eff > MAX_DIM_S) fw_eff = MAX_DIM_S;
      if (fh_eff > MAX_DIM_S) fh_eff = MAX_DIM_S;
   end

   always_ff @(posedge clock) begin
      if (ld4) begin
         f_x1_ff      <= clip_lo(fx_start);
         f_x2_ff      <= clip_hi(fx_start, fx_size, fw_eff);
         f_y1_ff      <= clip_lo(fy_start);
         f_y2_ff      <= clip_hi(fy_start, fy_size, fh_eff);
         f_zero_ff    <= (fx_size == '0) || (fy_size == '0);
         b_x1_ff      <= clip_lo(bx_start);
         b_x2_ff      <= clip_hi(bx_start, bx_size, fw_eff);
         b_y1_ff      <= clip_lo(by_start);
         b_y2_ff      <= clip_hi(by_start, by_size, fh_eff);
         b_zero_ff    <= (bx_size == '0) || (by_size == '0);
         use_face4_ff <= use_face3_ff;
         track4_ff    <= track3_ff;
      end
   end

   // An empty clip gives a negative or zero extent, which fails the two pixel test.
   always_comb begin
      f_w  = f_x2_ff - f_x1_ff;
      f_h  = f_y2_ff - f_y1_ff;
      b_w  = b_x2_ff - b_x1_ff;
      b_h  = b_y2_ff - b_y1_ff;
      f_ok = !f_zero_ff && (f_w >= 2) && (f_h >= 2);
      b_ok = !b_zero_ff && (b_w >= 2) && (b_h >= 2);
      take_face    = use_face4_ff && f_ok;
      rsp_valid_in = v4_ff && (take_face || b_ok);

      rsp_data_in.roi_left       = take_face ? f_x1_ff[11:0] : b_x1_ff[11:0];
      rsp_data_in.roi_top        = take_face ? f_y1_ff[11:0] : b_y1_ff[11:0];
      rsp_data_in.roi_width      = take_face ? f_w[12:0] : b_w[12:0];
      rsp_data_in.roi_height     = take_face ? f_h[12:0] : b_h[12:0];
      rsp_data_in.source_track   = track4_ff;
      rsp_data_in.source_is_face = track4_ff[15];
      rsp_data_in.target_is_face = take_face;
   end

   always_ff @(posedge clock) begin
      if (ldo) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A box without the anonymize flag never enters the pipeline.
   a_drop_unflagged: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_data.anonymize_flag |=> !v1_ff)
      else $error("unflagged box entered the pipeline");

   // Input back pressure only happens when every stage holds a box.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff && v2_ff && v3_ff && v4_ff && rsp_valid_ff)
      else $error("input stalled with a free stage");

   // A held stage keeps its box.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !ld2 |=> v2_ff)
      else $error("stalled box lost in stage two");

   // A face region can only come out with face mode on.
   a_face_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.target_is_face |-> face_mode_ff)
      else $error("face region without face mode");

endmodule
